FILE: design/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the stack machine arithmetic unit.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int WORD_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = $clog2(WORD_WIDTH + 1);

  localparam int REQ_W    = 3;
  localparam int LINE_W   = 32;
  localparam int STATUS_W = 2;

  localparam int IN_BITS    = REQ_W + WORD_WIDTH + LINE_W;
  localparam int OUT_BITS   = STATUS_W + WORD_WIDTH + DEPTH_W + LINE_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 3'd0,
    REQ_ADD  = 3'd1,
    REQ_SUB  = 3'd2,
    REQ_MUL  = 3'd3,
    REQ_DIV  = 3'd4,
    REQ_MOD  = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

FILE: design/sma_div.sv
// ----------------------------------------------------------------------------
// sma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sma_div import sma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] dividend,
  input  logic [WORD_WIDTH-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] quotient,
  output logic [WORD_WIDTH-1:0] remainder
);

  logic [WORD_WIDTH-1:0] quo_r, quo_nxt;
  logic [WORD_WIDTH-1:0] rem_r, rem_nxt;
  logic [WORD_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH:0]   diff;

  assign trial = {rem_r, quo_r[WORD_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(WORD_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Keep the trial difference when it did not go negative.
      rem_nxt = diff[WORD_WIDTH] ? trial[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
      quo_nxt = {quo_r[WORD_WIDTH-2:0], ~diff[WORD_WIDTH]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: design/stack_machine_arithmetic_top.sv
// ----------------------------------------------------------------------------
// stack_machine_arithmetic_top
// Arithmetic unit of a bytecode stack machine with a memory-held stack.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream (push, add, sub, mul, div, mod) and
//   each request produces exactly one result transfer on the out_ stream,
//   carrying a status code, the new top of stack, the stack depth and the
//   failing line number.
//   The top word lives in a register; all words below it live in a
//   single-port-read, single-port-write synchronous memory. A binary
//   operation reads the second word from memory through a registered
//   read port, and a push writes the old top word back into memory.
//   Sequencing: one request is in flight at a time. Push, add, sub, mul,
//   unknown codes and every rejected request pass through the read step
//   and then the final step, after which a new request can be taken.
//   Div and mod requests that pass their checks run the shared iterative
//   divider, one quotient bit per cycle, in a divide step between the
//   read step and the final step.
//   Reset empties the stack (depth zero) and the output register; memory
//   contents are not cleared since only entries below the depth are read.
//   When the receiver stalls, the finished result stays in the output
//   register and the block can still take and work on the next request;
//   that request then waits in its final step until the output is free.
// ----------------------------------------------------------------------------
module stack_machine_arithmetic_top import sma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // req_type [2:0], push_value [34:3], line_number [66:35], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status [1:0], top_value [33:2], stack_depth [44:34], error_line [76:45],
  // zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [WORD_WIDTH-1:0] val_r, val_nxt;
  logic [LINE_W-1:0]     line_r, line_nxt;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [WORD_WIDTH-1:0] tos_r, tos_nxt;
  logic [WORD_WIDTH-1:0] res_r, res_nxt;
  status_t               st_r, st_nxt;
  logic                  neg_a_r, neg_a_nxt;
  logic                  neg_b_r, neg_b_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Stack memory: entries below the top word.
  logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  wr_en;

  logic                  in_fire;
  logic                  fin_fire;
  logic                  is_push, is_bin, is_divmod;
  logic [WORD_WIDTH-1:0] op_a, op_b;
  logic [WORD_WIDTH-1:0] mag_a, mag_b;
  logic                  div_start, div_busy, div_done;
  logic [WORD_WIDTH-1:0] div_quot, div_rem;
  logic [DEPTH_W-1:0]    fin_depth;
  logic [WORD_WIDTH-1:0] fin_top;
  logic [LINE_W-1:0]     fin_line;
  logic [DEPTH_W-1:0]    depth_m1, depth_m2;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign fin_fire  = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  assign is_push   = (req_r == REQ_PUSH);
  assign is_divmod = (req_r == REQ_DIV) || (req_r == REQ_MOD);
  assign is_bin    = (req_r == REQ_ADD) || (req_r == REQ_SUB) || (req_r == REQ_MUL) ||
                     is_divmod;

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);

  // The second word is fetched on every accepted request; it is only used
  // by binary operations when the depth is at least two.
  assign rd_addr = depth_m2[ADDR_W-1:0];
  assign wr_addr = depth_m1[ADDR_W-1:0];
  assign wr_en   = fin_fire && is_push && (st_r == ST_OK) && (depth_r != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= tos_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // a is the second word, b the top word.
  assign op_a  = rd_data_r;
  assign op_b  = tos_r;
  assign mag_a = op_a[WORD_WIDTH-1] ? (~op_a + WORD_WIDTH'(1)) : op_a;
  assign mag_b = op_b[WORD_WIDTH-1] ? (~op_b + WORD_WIDTH'(1)) : op_b;

  sma_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // What the final step commits: a successful push grows the stack, a
  // successful binary operation shrinks it, anything else leaves it alone.
  always_comb begin
    fin_depth = depth_r;
    fin_top   = tos_r;
    if (st_r == ST_OK && is_push) begin
      fin_depth = depth_r + DEPTH_W'(1);
      fin_top   = val_r;
    end else if (st_r == ST_OK && is_bin) begin
      fin_depth = depth_m1;
      fin_top   = res_r;
    end
    if (fin_depth == '0) begin
      fin_top = '0;
    end
    fin_line = (st_r == ST_OK) ? '0 : line_r;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    val_nxt        = val_r;
    line_nxt       = line_r;
    depth_nxt      = depth_r;
    tos_nxt        = tos_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    neg_a_nxt      = neg_a_r;
    neg_b_nxt      = neg_b_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = in_tdata[REQ_W-1:0];
          val_nxt   = in_tdata[REQ_W +: WORD_WIDTH];
          line_nxt  = in_tdata[REQ_W + WORD_WIDTH +: LINE_W];
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        st_nxt    = ST_OK;
        res_nxt   = '0;
        neg_a_nxt = op_a[WORD_WIDTH-1];
        neg_b_nxt = op_b[WORD_WIDTH-1];
        state_nxt = S_FIN;
        if (is_push) begin
          if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
            st_nxt = ST_FULL;
          end
        end else if (is_bin) begin
          if (depth_r < DEPTH_W'(2)) begin
            st_nxt = ST_SHORT;
          end else if (is_divmod && op_b == '0) begin
            st_nxt = ST_DIVZERO;
          end else if (is_divmod) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            case (req_r)
              REQ_ADD: res_nxt = op_a + op_b;
              REQ_SUB: res_nxt = op_a - op_b;
              REQ_MUL: res_nxt = op_a * op_b;
              default: res_nxt = '0;
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // Quotient sign follows both operands, remainder sign the dividend.
          if (req_r == REQ_DIV) begin
            res_nxt = (neg_a_r != neg_b_r) ? (~div_quot + WORD_WIDTH'(1)) : div_quot;
          end else begin
            res_nxt = neg_a_r ? (~div_rem + WORD_WIDTH'(1)) : div_rem;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_fire) begin
          depth_nxt      = fin_depth;
          tos_nxt        = fin_top;
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({fin_line, fin_depth, fin_top, st_r});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    val_r       <= val_nxt;
    line_r      <= line_nxt;
    tos_r       <= tos_nxt;
    res_r       <= res_nxt;
    st_r        <= st_nxt;
    neg_a_r     <= neg_a_nxt;
    neg_b_r     <= neg_b_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      depth_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The stack never holds more than STACK_DEPTH words, top register included.
  assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // Depth moves by at most one word per request.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && depth_r != $past(depth_r)) |->
      (depth_r == $past(depth_r) + DEPTH_W'(1) || depth_r == $past(depth_r) - DEPTH_W'(1)))
    else $error("stack depth jumped");

  // The divider only runs while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider busy outside the divide step");

  // A successful result never reports an error line.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[STATUS_W-1:0] == ST_OK) |->
      (out_tdata_r[STATUS_W + WORD_WIDTH + DEPTH_W +: LINE_W] == '0))
    else $error("error line set on a successful result");

endmodule

FILE: bench/tb_stack_machine_arithmetic_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_machine_arithmetic_top
// Self-checking bench for the stack machine arithmetic unit. A table of
// directed requests runs first: an empty stack, the word extremes, the
// MIN / -1 and MIN % -1 wraps, division by zero and unknown codes. After it
// come random request streams, the last one without any idling. A
// behavioral stack model predicts every result, and results are compared
// field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_stack_machine_arithmetic_top;
  import sma_pkg::*;

  // Request codes beyond the defined set; the block must ignore them.
  localparam logic [REQ_W-1:0] REQ_UNUSED6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED7 = 3'd7;

  localparam logic [WORD_WIDTH-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_WIDTH-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_WIDTH-1:0] WORD_M1  = 32'hFFFF_FFFF;

  // Guard on the run length, well above the slowest correct run.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles allowed after the last result, longer than one division.
  localparam int TAIL_CYCLES = 60;

  // One result transfer, unpacked.
  typedef struct {
    status_t               status;
    logic [WORD_WIDTH-1:0] top;
    logic [DEPTH_W-1:0]    depth;
    logic [LINE_W-1:0]     err_line;
  } stack_result_t;

  // One row of the directed table. Where has_want is set the expected
  // result is written into the row; otherwise the stack model supplies it.
  typedef struct {
    logic [REQ_W-1:0]      req;
    logic [WORD_WIDTH-1:0] value;
    logic [LINE_W-1:0]     line;
    bit                    has_want;
    stack_result_t         want;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Behavioral copy of the stack, updated at each accepted request.
  logic [WORD_WIDTH-1:0] model_stack [0:STACK_DEPTH-1];
  int                    model_fill;

  // Results still owed by the block, oldest first.
  stack_result_t         pending_results [$];

  int                    error_count = 0;
  int                    cycle_count = 0;
  int                    rx_stall_left = 0;
  // When set, neither side inserts idle cycles.
  bit                    quiet;

  stack_machine_arithmetic_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 8 ns clock period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run-length guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Applies one request to the stack model and returns the result the
  // block should produce. Arithmetic is done on unsigned bit vectors so
  // that the wraps are explicit rather than left to the language.
  function automatic stack_result_t apply_request(input logic [REQ_W-1:0] req,
                                                  input logic [WORD_WIDTH-1:0] value,
                                                  input logic [LINE_W-1:0] line);
    stack_result_t         res;
    logic [WORD_WIDTH-1:0] a, b, r, mag_a, mag_b, q, m;
    bit                    neg_a, neg_b;
    res.status = ST_OK;
    if (req == REQ_PUSH) begin
      if (model_fill >= STACK_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        model_stack[model_fill] = value;
        model_fill++;
      end
    end else if (req <= REQ_MOD) begin
      if (model_fill < 2) begin
        res.status = ST_SHORT;
      end else begin
        b = model_stack[model_fill-1];
        a = model_stack[model_fill-2];
        if ((req == REQ_DIV || req == REQ_MOD) && b == '0) begin
          res.status = ST_DIVZERO;
        end else begin
          neg_a = a[WORD_WIDTH-1];
          neg_b = b[WORD_WIDTH-1];
          mag_a = neg_a ? -a : a;
          mag_b = neg_b ? -b : b;
          case (req)
            REQ_ADD: r = a + b;
            REQ_SUB: r = a - b;
            REQ_MUL: r = a * b;
            REQ_DIV: begin
              // Truncating division; MIN / -1 comes out as MIN again.
              q = mag_a / mag_b;
              r = (neg_a != neg_b) ? -q : q;
            end
            default: begin
              // The remainder takes the sign of the dividend.
              m = mag_a % mag_b;
              r = neg_a ? -m : m;
            end
          endcase
          model_stack[model_fill-2] = r;
          model_fill--;
        end
      end
    end
    // Unknown codes fall through with the stack untouched.
    res.top      = (model_fill > 0) ? model_stack[model_fill-1] : '0;
    res.depth    = model_fill[DEPTH_W-1:0];
    res.err_line = (res.status != ST_OK) ? line : '0;
    return res;
  endfunction

  // Offers one request and holds it until the block takes it. Entered and
  // left at a falling edge. The expected result is queued at the transfer.
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [WORD_WIDTH-1:0] value,
                              input logic [LINE_W-1:0] line,
                              input bit has_want, input stack_result_t want);
    stack_result_t predicted;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, line, value, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_request(req, value, line);
    pending_results.push_back(has_want ? want : predicted);
    @(negedge clk);
  endtask

  // Word values lean toward the corners of the signed range and zero, so
  // that wraps and zero divisors turn up often.
  function automatic logic [WORD_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WORD_MIN;
      2: return WORD_MAX;
      3: return WORD_M1;
      4: return WORD_WIDTH'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LINE_W-1:0] pick_line();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Picks a request code. With a shallow stack most requests are pushes so
  // that binary operations usually find two operands; the remainder are
  // requests on a short stack and unknown codes.
  function automatic logic [REQ_W-1:0] pick_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (model_fill < 2) begin
      if (roll < 70) return REQ_PUSH;
      if (roll < 90) return REQ_W'($urandom_range(REQ_ADD, REQ_MOD));
    end else if (model_fill > 12) begin
      if (roll < 20) return REQ_PUSH;
      if (roll < 95) return REQ_W'($urandom_range(REQ_ADD, REQ_MOD));
    end else begin
      if (roll < 45) return REQ_PUSH;
      if (roll < 95) return REQ_W'($urandom_range(REQ_ADD, REQ_MOD));
    end
    return $urandom_range(0, 1) ? REQ_UNUSED6 : REQ_UNUSED7;
  endfunction

  // Receiver: random stall bursts, driven at the falling edge.
  always @(negedge clk) begin
    if (!quiet && rx_stall_left == 0 && $urandom_range(0, 11) == 0)
      rx_stall_left = $urandom_range(1, 13);
    if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker: each transfer is matched against the oldest entry.
  always @(posedge clk) begin
    stack_result_t want;
    logic [STATUS_W-1:0] got_status;
    logic [WORD_WIDTH-1:0] got_top;
    logic [DEPTH_W-1:0] got_depth;
    logic [LINE_W-1:0] got_line;
    if (rst_n && out_tvalid && out_tready) begin
      got_status = out_tdata[1:0];
      got_top    = out_tdata[33:2];
      got_depth  = out_tdata[44:34];
      got_line   = out_tdata[76:45];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(got_status), 32'(got_depth));
      end else begin
        want = pending_results.pop_front();
        if (got_status !== want.status)
          report_mismatch("status", 32'(got_status), 32'(want.status));
        if (got_top !== want.top)
          report_mismatch("top_value", got_top, want.top);
        if (got_depth !== want.depth)
          report_mismatch("stack_depth", 32'(got_depth), 32'(want.depth));
        if (got_line !== want.err_line)
          report_mismatch("error_line", got_line, want.err_line);
      end
    end
  end

  // Directed table. The first rows start from the empty stack after reset,
  // so their results are written out; from the second add onward the stack
  // model gives the expected values.
  directed_row_t directed_rows [] = '{
    // Binary operation on an empty stack is rejected, highest line echoed.
    '{REQ_ADD,     32'h0,    32'hFFFF_FFFF, 1'b1, '{ST_SHORT, 32'h0, 11'd0, 32'hFFFF_FFFF}},
    // Unknown code on an empty stack reports an empty stack and no error.
    '{REQ_UNUSED6, WORD_MAX, 32'd5,         1'b1, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    WORD_MIN, 32'd0,         1'b1, '{ST_OK, WORD_MIN, 11'd1, 32'h0}},
    // One word is still too short.
    '{REQ_SUB,     32'h0,    32'd7,         1'b1, '{ST_SHORT, WORD_MIN, 11'd1, 32'd7}},
    '{REQ_PUSH,    WORD_M1,  32'd1,         1'b1, '{ST_OK, WORD_M1, 11'd2, 32'h0}},
    // MIN / -1 wraps back to MIN.
    '{REQ_DIV,     32'h0,    32'd2,         1'b1, '{ST_OK, WORD_MIN, 11'd1, 32'h0}},
    '{REQ_PUSH,    WORD_M1,  32'd3,         1'b1, '{ST_OK, WORD_M1, 11'd2, 32'h0}},
    // MIN % -1 is zero.
    '{REQ_MOD,     32'h0,    32'd4,         1'b1, '{ST_OK, 32'h0, 11'd1, 32'h0}},
    '{REQ_PUSH,    32'h0,    32'd6,         1'b1, '{ST_OK, 32'h0, 11'd2, 32'h0}},
    // Zero divisor leaves the stack alone and echoes the line.
    '{REQ_DIV,     32'h0,    32'hAAAA_5555, 1'b1, '{ST_DIVZERO, 32'h0, 11'd2, 32'hAAAA_5555}},
    '{REQ_MOD,     32'h0,    32'h5555_AAAA, 1'b1, '{ST_DIVZERO, 32'h0, 11'd2, 32'h5555_AAAA}},
    '{REQ_ADD,     32'h0,    32'h8000_0001, 1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    WORD_MAX, 32'd10,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    WORD_MAX, 32'd11,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_ADD,     32'h0,    32'd12,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    WORD_MIN, 32'd13,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_SUB,     32'h0,    32'd14,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    WORD_MAX, 32'd15,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_MUL,     32'h0,    32'd16,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    -32'sd7,  32'd17,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    32'd2,    32'd18,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_DIV,     32'h0,    32'd19,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_PUSH,    32'd3,    32'd20,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_MOD,     32'h0,    32'd21,        1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}},
    '{REQ_UNUSED7, WORD_M1,  32'd0,         1'b0, '{ST_OK, 32'h0, 11'd0, 32'h0}}
  };

  // Main sequence.
  initial begin
    stack_result_t no_want;
    no_want       = '{ST_OK, '0, '0, '0};
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    out_tready    <= 1'b0;
    quiet         = 1'b0;
    model_fill    = 0;

    // Reset held, then released at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].value, directed_rows[i].line,
                   directed_rows[i].has_want, directed_rows[i].want);

    // First random stream; idling on both sides comes and goes in stretches.
    for (int n = 0; n < 250; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_request(pick_request(), pick_word(), pick_line(), 1'b0, no_want);
    end
    quiet = 1'b1;

    // Hold the sender back until every owed result has arrived and the
    // receiver has finished its last stall.
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 || rx_stall_left != 0) @(negedge clk);

    // Final random stream with both sides running flat out.
    for (int n = 0; n < 175; n++)
      send_request(pick_request(), pick_word(), pick_line(), 1'b0, no_want);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: stack_machine_arithmetic_top.f
design/sma_pkg.sv
design/sma_div.sv
design/stack_machine_arithmetic_top.sv
bench/tb_stack_machine_arithmetic_top.sv
